// ----- hdl/dhqp_pkg.sv -----
// Package for the DNS header and question parser.
// Holds the result kinds, parse phases, word types and size constants.
// No dependencies; every other file of the block but dhqp_if imports it.
`timescale 1ns / 1ps

package dhqp_pkg;

  // Longest dotted name that is reported character by character.
  localparam int unsigned NameLimitDef = 255;
  // Name length counter holds up to the limit plus one.
  localparam int unsigned NameCntW = 9;

  typedef enum logic [3:0] {
    KIND_ID       = 4'd0,
    KIND_FLAGS    = 4'd1,
    KIND_QDCOUNT  = 4'd2,
    KIND_ANCOUNT  = 4'd3,
    KIND_NSCOUNT  = 4'd4,
    KIND_ARCOUNT  = 4'd5,
    KIND_CHAR     = 4'd6,
    KIND_END      = 4'd7,
    KIND_QTYPE    = 4'd8,
    KIND_QCLASS   = 4'd9,
    KIND_OVERFLOW = 4'd10
  } kind_e;

  typedef enum logic [9:0] {
    PH_IDLE     = 10'b00_0000_0001,
    PH_HDR_HI   = 10'b00_0000_0010,
    PH_HDR_LO   = 10'b00_0000_0100,
    PH_LEN      = 10'b00_0000_1000,
    PH_LABEL    = 10'b00_0001_0000,
    PH_TYPE_HI  = 10'b00_0010_0000,
    PH_TYPE_LO  = 10'b00_0100_0000,
    PH_CLASS_HI = 10'b00_1000_0000,
    PH_CLASS_LO = 10'b01_0000_0000,
    PH_DONE     = 10'b10_0000_0000
  } phase_e;

  localparam logic [7:0] DotChar = 8'h2E;

  typedef struct packed {
    logic [7:0] msg_byte;
    logic       start_of_message;
  } in_word_t;

  typedef struct packed {
    kind_e       kind;
    logic [15:0] field_value;
    logic [15:0] question_number;
    logic        is_response;
    logic [3:0]  op_code;
    logic        authoritative;
    logic        truncated;
    logic        recursion_desired;
    logic        recursion_available;
    logic [2:0]  reserved_bits;
    logic [3:0]  response_code;
  } res_t;

endpackage

// ----- hdl/dhqp_if.sv -----
// Channel interfaces of the DNS header and question parser.
// dhqp_in_if carries message bytes, dhqp_out_if carries result words.
// No dependencies.
`timescale 1ns / 1ps

interface dhqp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] msg_byte;
  logic       start_of_message;

  modport source (output valid, output msg_byte, output start_of_message, input ready);
  modport sink (input valid, input msg_byte, input start_of_message, output ready);
endinterface

interface dhqp_out_if;
  logic        valid;
  logic        ready;
  logic [3:0]  item_kind;
  logic [15:0] field_value;
  logic [15:0] question_number;
  logic        is_response;
  logic [3:0]  op_code;
  logic        authoritative;
  logic        truncated;
  logic        recursion_desired;
  logic        recursion_available;
  logic [2:0]  reserved_bits;
  logic [3:0]  response_code;

  modport source (
    output valid, output item_kind, output field_value, output question_number,
    output is_response, output op_code, output authoritative, output truncated,
    output recursion_desired, output recursion_available, output reserved_bits,
    output response_code, input ready
  );
  modport sink (
    input valid, input item_kind, input field_value, input question_number,
    input is_response, input op_code, input authoritative, input truncated,
    input recursion_desired, input recursion_available, input reserved_bits,
    input response_code, output ready
  );
endinterface

// ----- hdl/dhqp_in_reg.sv -----
// Input register of the DNS header and question parser.
// Captures one byte word from the input channel; depends on dhqp_pkg, dhqp_if.
`timescale 1ns / 1ps

module dhqp_in_reg import dhqp_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  dhqp_in_if.sink  in_i,
  input  logic     take_i,
  output logic     valid_o,
  output in_word_t word_o
);

  logic     valid_q, valid_d;
  in_word_t word_q;

  // A new word may enter when the register is empty or the held one leaves in the same cycle.
  assign in_i.ready = !valid_q || take_i;

  always_comb begin
    valid_d = valid_q;
    if (in_i.ready) begin
      valid_d = in_i.valid;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.ready && in_i.valid) begin
      word_q <= '{msg_byte: in_i.msg_byte, start_of_message: in_i.start_of_message};
    end
  end

  assign valid_o = valid_q;
  assign word_o  = word_q;

endmodule

// ----- hdl/dhqp_core.sv -----
// Parse state and result logic of the DNS header and question parser.
// Updates the parse state once per byte word; depends on dhqp_pkg.
`timescale 1ns / 1ps

module dhqp_core import dhqp_pkg::*; #(
  parameter int unsigned NameLimit = NameLimitDef
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     take_i,
  input  in_word_t word_i,
  output logic     res_valid_o,
  output res_t     res_o
);

  localparam logic [NameCntW-1:0] LimitC   = NameCntW'(NameLimit);
  localparam logic [NameCntW-1:0] LimitP1C = NameCntW'(NameLimit + 1);

  phase_e              phase_q, phase_d, ph;
  logic [2:0]          hidx_q, hidx_d, hidx;
  logic [7:0]          held_q, held_d, held;
  logic [15:0]         ql_q, ql_d, ql;
  logic [15:0]         cq_q, cq_d, cq;
  logic [7:0]          lbl_q, lbl_d, lbl;
  logic [NameCntW-1:0] nlc_q, nlc_d, nlc;
  logic                first_q, first_d, first;

  logic [7:0]  b;
  logic [15:0] word;
  logic [7:0]  nc_char;
  logic        nc_req;
  logic [15:0] ql_dec;
  logic [7:0]  lbl_dec;

  assign b       = word_i.msg_byte;
  assign word    = {held, b};
  assign ql_dec  = ql - 16'd1;
  assign lbl_dec = lbl - 8'd1;

  // A start flag makes the byte the first one of a fresh message.
  always_comb begin
    if (word_i.start_of_message) begin
      ph = PH_HDR_HI;  hidx = '0;  held = '0;  ql = '0;
      cq = '0;  lbl = '0;  nlc = '0;  first = 1'b1;
    end else begin
      ph = phase_q;  hidx = hidx_q;  held = held_q;  ql = ql_q;
      cq = cq_q;  lbl = lbl_q;  nlc = nlc_q;  first = first_q;
    end
  end

  always_comb begin
    phase_d = ph;  hidx_d = hidx;  held_d = held;  ql_d = ql;
    cq_d = cq;  lbl_d = lbl;  nlc_d = nlc;  first_d = first;
    res_valid_o = 1'b0;
    res_o = '0;
    nc_req = 1'b0;
    nc_char = b;

    unique case (ph)
      PH_HDR_HI: begin
        held_d  = b;
        phase_d = PH_HDR_LO;
      end
      PH_HDR_LO: begin
        res_valid_o       = 1'b1;
        res_o.kind        = kind_e'({1'b0, hidx});
        res_o.field_value = word;
        if (hidx == 3'(KIND_FLAGS)) begin
          res_o.is_response         = word[15];
          res_o.op_code             = word[14:11];
          res_o.authoritative       = word[10];
          res_o.truncated           = word[9];
          res_o.recursion_desired   = word[8];
          res_o.recursion_available = word[7];
          res_o.reserved_bits       = word[6:4];
          res_o.response_code       = word[3:0];
        end
        if (hidx == 3'(KIND_QDCOUNT)) begin
          ql_d = word;
        end
        if (hidx >= 3'(KIND_ARCOUNT)) begin
          hidx_d = '0;
          cq_d   = '0;
          if (ql == '0) begin
            phase_d = PH_DONE;
          end else begin
            phase_d = PH_LEN;  lbl_d = '0;  nlc_d = '0;  first_d = 1'b1;
          end
        end else begin
          hidx_d  = hidx + 3'd1;
          phase_d = PH_HDR_HI;
        end
      end
      PH_LEN: begin
        if (b == '0) begin
          phase_d               = PH_TYPE_HI;
          res_valid_o           = 1'b1;
          res_o.kind            = KIND_END;
          res_o.question_number = cq;
        end else begin
          lbl_d   = b;
          phase_d = PH_LABEL;
          if (first) begin
            first_d = 1'b0;
          end else begin
            nc_req  = 1'b1;
            nc_char = DotChar;
          end
        end
      end
      PH_LABEL: begin
        lbl_d  = lbl_dec;
        nc_req = 1'b1;
        if (lbl_dec == '0) begin
          phase_d = PH_LEN;
        end
      end
      PH_TYPE_HI: begin
        held_d  = b;
        phase_d = PH_TYPE_LO;
      end
      PH_CLASS_HI: begin
        held_d  = b;
        phase_d = PH_CLASS_LO;
      end
      PH_TYPE_LO: begin
        res_valid_o           = 1'b1;
        res_o.kind            = KIND_QTYPE;
        res_o.field_value     = word;
        res_o.question_number = cq;
        phase_d               = PH_CLASS_HI;
      end
      PH_CLASS_LO: begin
        res_valid_o           = 1'b1;
        res_o.kind            = KIND_QCLASS;
        res_o.field_value     = word;
        res_o.question_number = cq;
        ql_d                  = ql_dec;
        if (ql_dec == '0) begin
          phase_d = PH_DONE;
        end else begin
          cq_d    = cq + 16'd1;
          phase_d = PH_LEN;  lbl_d = '0;  nlc_d = '0;  first_d = 1'b1;
        end
      end
      PH_IDLE, PH_DONE: begin
      end
      default: begin
      end
    endcase

    // Name characters count against the limit; the first one past it is
    // reported as an overflow and the rest of the name is dropped.
    if (nc_req) begin
      res_o.question_number = cq;
      if (nlc == LimitC) begin
        nlc_d       = LimitP1C;
        res_valid_o = 1'b1;
        res_o.kind  = KIND_OVERFLOW;
      end else if (nlc < LimitC) begin
        nlc_d             = nlc + 1'b1;
        res_valid_o       = 1'b1;
        res_o.kind        = KIND_CHAR;
        res_o.field_value = {8'h00, nc_char};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      hidx_q  <= '0;
      held_q  <= '0;
      ql_q    <= '0;
      cq_q    <= '0;
      lbl_q   <= '0;
      nlc_q   <= '0;
      first_q <= 1'b1;
    end else if (take_i) begin
      phase_q <= phase_d;
      hidx_q  <= hidx_d;
      held_q  <= held_d;
      ql_q    <= ql_d;
      cq_q    <= cq_d;
      lbl_q   <= lbl_d;
      nlc_q   <= nlc_d;
      first_q <= first_d;
    end
  end

`ifndef SYNTHESIS
  a_label_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_LABEL |-> lbl_q != '0)
    else $error("label phase with no label bytes left");

  a_name_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    nlc_q <= LimitP1C)
    else $error("name length count past limit plus one");

  a_done_no_questions: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_DONE |-> ql_q == '0)
    else $error("parse finished with questions left");

  a_char_counted: assert property (@(posedge clk_i) disable iff (!rst_ni)
    take_i && res_valid_o && res_o.kind == KIND_CHAR |=> nlc_q != '0 && nlc_q <= LimitC)
    else $error("name character emitted outside the length limit");
`endif

endmodule

// ----- hdl/dhqp_out_reg.sv -----
// Result register of the DNS header and question parser.
// Holds one result word for the output channel; depends on dhqp_pkg, dhqp_if.
`timescale 1ns / 1ps

module dhqp_out_reg import dhqp_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       load_i,
  input  res_t       res_i,
  output logic       can_load_o,
  dhqp_out_if.source out_o
);

  logic valid_q, valid_d;
  res_t res_q;

  assign can_load_o = !valid_q || out_o.ready;

  always_comb begin
    valid_d = valid_q;
    if (can_load_o) begin
      valid_d = load_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (can_load_o && load_i) begin
      res_q <= res_i;
    end
  end

  assign out_o.valid               = valid_q;
  assign out_o.item_kind           = res_q.kind;
  assign out_o.field_value         = res_q.field_value;
  assign out_o.question_number     = res_q.question_number;
  assign out_o.is_response         = res_q.is_response;
  assign out_o.op_code             = res_q.op_code;
  assign out_o.authoritative       = res_q.authoritative;
  assign out_o.truncated           = res_q.truncated;
  assign out_o.recursion_desired   = res_q.recursion_desired;
  assign out_o.recursion_available = res_q.recursion_available;
  assign out_o.reserved_bits       = res_q.reserved_bits;
  assign out_o.response_code       = res_q.response_code;

endmodule

// ----- hdl/dns_header_question_parser.sv -----
// DNS header and question parser: takes one message byte per word, with a
// start flag on the first byte, and reports the six header words (flags split
// into fields), then for each question its name characters with dots, an end
// mark, qtype and qclass; names past NameLimit characters give one overflow
// word. One byte is taken every clock cycle while the output does not stall;
// a result is made from the byte in the input register by the combinational
// parse step and held in the result register. Output stalls hold input off
// only with both registers full. Depends on dhqp_pkg, dhqp_if, dhqp modules.
`timescale 1ns / 1ps

module dns_header_question_parser import dhqp_pkg::*; #(
  parameter int unsigned NameLimit = NameLimitDef
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  dhqp_in_if.sink    in_i,
  dhqp_out_if.source out_o
);

  logic     in_valid;
  in_word_t in_word;
  logic     can_load;
  logic     take;
  logic     res_valid;
  res_t     res;

  // A byte leaves the input register only when the result register has room.
  assign take = in_valid && can_load;

  dhqp_in_reg u_in_reg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (in_i),
    .take_i  (take),
    .valid_o (in_valid),
    .word_o  (in_word)
  );

  dhqp_core #(
    .NameLimit (NameLimit)
  ) u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .take_i      (take),
    .word_i      (in_word),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  dhqp_out_reg u_out_reg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .load_i     (take && res_valid),
    .res_i      (res),
    .can_load_o (can_load),
    .out_o      (out_o)
  );

endmodule
